>>> rtl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Checks are compiled in simulation only; synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that is switched off while reset is asserted.
`define FFHA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: check failed");
// Check that also holds while reset is asserted.
`define FFHA_ASSERT_RST(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("%m: check failed during reset");
`else
`define FFHA_ASSERT(lbl, clk, rst_n, prop)
`define FFHA_ASSERT_RST(lbl, clk, prop)
`endif
`endif

>>> rtl/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

	localparam int SIZE_W   = 10;
	localparam int OFFSET_W = 10;
	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_FIT   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_ADDR = 2'd2;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// Datapath operation for the current cycle.
	typedef enum logic [3:0] {
		DP_IDLE,
		DP_LOAD,
		DP_WALK_READ,
		DP_WALK_EVAL,
		DP_SPLIT_WRITE,
		DP_MERGE_READ0,
		DP_MERGE_LOAD0,
		DP_MERGE_READ,
		DP_MERGE_EVAL,
		DP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic req_null;
		logic free_cmd;
		logic fit;
		logic split;
		logic match;
		logic chain_end;
		logic merge_end;
	} dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator with block split and free merge.
// Depends on ffha_pkg, ffha_ctrl and ffha_dp.
//
//   channel   direction   handshake               beat contents
//   request   in          req_valid / req_stall   command, request_size, payload_offset
//   response  out         rsp_valid / rsp_stall   result_offset, status
//
// One request is served at a time. Each block header visited takes a read of the header
// memory and then an evaluation of it. An allocate passes through the accept, the walk,
// the split write when the block is split, and the finish step that loads the response.
// A free walks in the same way to its block; the merge pass then starts with a read and a
// load of the first header, takes a read and an evaluation per header step and a last
// read to find the end of the chain, so the header memory accesses set the pace.
// There is no clearing pass after reset: only the first header has a reset value, and a
// flag stands in for it until that entry is first written.
// A finished response waits in the output register while rsp_stall is high; the next
// request is already accepted and worked on, and only its own response then waits.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_heap_allocator #(
	parameter int HEAP_BYTES   = 1024,
	parameter int HEADER_BYTES = 24
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              req_valid,
	output logic                             req_stall,
	input  wire                              command,
	input  wire  [ffha_pkg::SIZE_W-1:0]      request_size,
	input  wire  [ffha_pkg::OFFSET_W-1:0]    payload_offset,
	output logic                             rsp_valid,
	input  wire                              rsp_stall,
	output logic [ffha_pkg::OFFSET_W-1:0]    result_offset,
	output logic [ffha_pkg::STATUS_W-1:0]    status
);

	// Commands from the controller and condition flags back from the datapath.
	ffha_pkg::dp_cmd_t  cmd;
	ffha_pkg::dp_stat_t stat;

	// The controller owns both handshakes and decides each cycle's datapath operation.
	ffha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The datapath holds the header memory, the walk pointer and the output register.
	ffha_dp #(
		.HEAP_BYTES   (HEAP_BYTES),
		.HEADER_BYTES (HEADER_BYTES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.command        (command),
		.request_size   (request_size),
		.payload_offset (payload_offset),
		.result_offset  (result_offset),
		.status         (status),
		.cmd            (cmd),
		.stat           (stat)
	);

endmodule

`default_nettype wire

>>> rtl/ffha_dp.sv
// Datapath of the allocator: header memory, walk pointer and result registers.
// Depends on ffha_pkg and assert_macros.svh; driven by ffha_ctrl.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ffha_dp #(
	parameter int HEAP_BYTES   = 1024,
	parameter int HEADER_BYTES = 24
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  command,
	input  wire  [ffha_pkg::SIZE_W-1:0]          request_size,
	input  wire  [ffha_pkg::OFFSET_W-1:0]        payload_offset,
	output logic [ffha_pkg::OFFSET_W-1:0]        result_offset,
	output logic [ffha_pkg::STATUS_W-1:0]        status,
	input  wire  ffha_pkg::dp_cmd_t              cmd,
	output ffha_pkg::dp_stat_t                   stat
);

	localparam int OFS_W = $clog2(HEAP_BYTES);
	localparam int ENT_W = OFS_W + 1;
	localparam int SUM_W = ((OFS_W > ffha_pkg::SIZE_W) ? OFS_W : ffha_pkg::SIZE_W) + 2;
	localparam logic [SUM_W-1:0] HEAP_S   = SUM_W'(HEAP_BYTES);
	localparam logic [SUM_W-1:0] HDR_S    = SUM_W'(HEADER_BYTES);
	localparam logic [OFS_W-1:0] INIT_LEN = OFS_W'(HEAP_BYTES - HEADER_BYTES);

	// Each entry holds the free mark above the payload length.
	logic [ENT_W-1:0] mem_q [HEAP_BYTES];
	logic [ENT_W-1:0] rd_data_q;
	logic             rd_zero_q;
	logic             e0_wr_q;

	logic                              free_cmd_q;
	logic [ffha_pkg::SIZE_W-1:0]       want_q;
	logic [ffha_pkg::OFFSET_W-1:0]     pay_q;
	logic [OFS_W-1:0]                  cur_q;
	logic [OFS_W-1:0]                  cur_len_q;
	logic                              cur_free_q;
	logic [OFS_W-1:0]                  nxt_q;
	logic [ffha_pkg::OFFSET_W-1:0]     res_off_q;
	logic [ffha_pkg::STATUS_W-1:0]     res_stat_q;
	logic [ffha_pkg::OFFSET_W-1:0]     out_off_q;
	logic [ffha_pkg::STATUS_W-1:0]     out_stat_q;

	logic             r_free;
	logic [OFS_W-1:0] r_len;
	logic [SUM_W-1:0] want_s, rlen_s, cur_pay_s, walk_nxt_s, rest_s, rest_len_s;
	logic [SUM_W-1:0] merge_nxt_s, merged_s;
	logic             fit, split, match, chain_end, merge_end;

	logic             rd_en, wr_en;
	logic [OFS_W-1:0] rd_addr, wr_addr;
	logic [ENT_W-1:0] wr_data;

	// Entry 0 reads as the initial whole-heap block until it is first written.
	assign r_free = (rd_zero_q && !e0_wr_q) ? 1'b1 : rd_data_q[OFS_W];
	assign r_len  = (rd_zero_q && !e0_wr_q) ? INIT_LEN : rd_data_q[OFS_W-1:0];

	assign want_s      = SUM_W'(want_q);
	assign rlen_s      = SUM_W'(r_len);
	assign cur_pay_s   = SUM_W'(cur_q) + HDR_S;
	assign walk_nxt_s  = cur_pay_s + rlen_s;
	assign rest_s      = cur_pay_s + want_s;
	assign rest_len_s  = rlen_s - want_s - HDR_S;
	assign merge_nxt_s = cur_pay_s + SUM_W'(cur_len_q);
	assign merged_s    = SUM_W'(cur_len_q) + HDR_S + rlen_s;

	assign fit       = r_free && (rlen_s >= want_s);
	assign split     = (rlen_s >= want_s + HDR_S + SUM_W'(1)) && (rest_s < HEAP_S);
	assign match     = cur_pay_s == SUM_W'(pay_q);
	assign chain_end = walk_nxt_s >= HEAP_S;
	assign merge_end = merge_nxt_s >= HEAP_S;

	always_comb begin
		stat.req_null  = (command == ffha_pkg::CMD_FREE) && (payload_offset == '0);
		stat.free_cmd  = free_cmd_q;
		stat.fit       = fit;
		stat.split     = split;
		stat.match     = match;
		stat.chain_end = chain_end;
		stat.merge_end = merge_end;
	end

	// Memory port decode.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cur_q;
		wr_en   = 1'b0;
		wr_addr = cur_q;
		wr_data = {1'b1, r_len};
		unique case (cmd.op)
			ffha_pkg::DP_WALK_READ: begin
				rd_en = 1'b1;
			end
			ffha_pkg::DP_MERGE_READ0: begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end
			ffha_pkg::DP_MERGE_READ: begin
				rd_en   = !merge_end;
				rd_addr = merge_nxt_s[OFS_W-1:0];
			end
			ffha_pkg::DP_WALK_EVAL: begin
				if (free_cmd_q) begin
					wr_en   = match;
					wr_data = {1'b1, r_len};
				end else begin
					wr_en   = fit;
					wr_data = {1'b0, split ? want_s[OFS_W-1:0] : r_len};
				end
			end
			ffha_pkg::DP_SPLIT_WRITE: begin
				wr_en   = 1'b1;
				wr_data = {1'b1, cur_len_q};
			end
			ffha_pkg::DP_MERGE_EVAL: begin
				wr_en   = cur_free_q && r_free;
				wr_data = {1'b1, merged_s[OFS_W-1:0]};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
			rd_zero_q <= rd_addr == '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e0_wr_q <= 1'b0;
		end else if (wr_en && (wr_addr == '0)) begin
			e0_wr_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			ffha_pkg::DP_LOAD: begin
				free_cmd_q <= command;
				want_q     <= request_size;
				pay_q      <= payload_offset;
				cur_q      <= '0;
				res_off_q  <= '0;
				res_stat_q <= ffha_pkg::STATUS_DONE;
			end
			ffha_pkg::DP_WALK_EVAL: begin
				if (!free_cmd_q && fit) begin
					res_off_q <= cur_pay_s[ffha_pkg::OFFSET_W-1:0];
					if (split) begin
						// The remainder's start and length wait here for the split write.
						cur_q     <= rest_s[OFS_W-1:0];
						cur_len_q <= rest_len_s[OFS_W-1:0];
					end
				end else if (!(free_cmd_q && match)) begin
					if (chain_end) begin
						res_stat_q <= free_cmd_q ? ffha_pkg::STATUS_BAD_ADDR
							: ffha_pkg::STATUS_NO_FIT;
					end else begin
						cur_q <= walk_nxt_s[OFS_W-1:0];
					end
				end
			end
			ffha_pkg::DP_MERGE_READ0: begin
				cur_q <= '0;
			end
			ffha_pkg::DP_MERGE_LOAD0: begin
				cur_len_q  <= r_len;
				cur_free_q <= r_free;
			end
			ffha_pkg::DP_MERGE_READ: begin
				nxt_q <= merge_nxt_s[OFS_W-1:0];
			end
			ffha_pkg::DP_MERGE_EVAL: begin
				if (cur_free_q && r_free) begin
					cur_len_q <= merged_s[OFS_W-1:0];
				end else begin
					cur_q      <= nxt_q;
					cur_len_q  <= r_len;
					cur_free_q <= r_free;
				end
			end
			default: begin
			end
		endcase
		if (cmd.out_load) begin
			out_off_q  <= res_off_q;
			out_stat_q <= res_stat_q;
		end
	end

	assign result_offset = out_off_q;
	assign status        = out_stat_q;

	`FFHA_ASSERT(a_read_in_heap, clk, arst_n, rd_en |-> (SUM_W'(rd_addr) < HEAP_S))
	`FFHA_ASSERT(a_no_rw_clash, clk, arst_n, (rd_en && wr_en) |-> (rd_addr != wr_addr))
	`FFHA_ASSERT(a_split_after_eval, clk, arst_n, (cmd.op == ffha_pkg::DP_SPLIT_WRITE) |-> ($past(cmd.op) == ffha_pkg::DP_WALK_EVAL))

endmodule

`default_nettype wire

>>> rtl/ffha_ctrl.sv
// Controller state machine of the allocator: sequences walk, split and merge.
// Depends on ffha_pkg and assert_macros.svh; drives ffha_dp.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ffha_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                req_valid,
	output logic               req_stall,
	output logic               rsp_valid,
	input  wire                rsp_stall,
	input  wire ffha_pkg::dp_stat_t stat,
	output ffha_pkg::dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_WALK_READ,
		S_WALK_EVAL,
		S_SPLIT_WRITE,
		S_MERGE_READ0,
		S_MERGE_LOAD0,
		S_MERGE_READ,
		S_MERGE_EVAL,
		S_FINISH
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   accept;
	logic   out_load;

	assign req_stall = state_q != S_IDLE;
	assign accept    = req_valid && !req_stall;
	assign out_load  = (state_q == S_FINISH) && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		cmd.op  = ffha_pkg::DP_IDLE;
		cmd.out_load = out_load;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.op  = ffha_pkg::DP_LOAD;
					state_d = stat.req_null ? S_FINISH : S_WALK_READ;
				end
			end
			S_WALK_READ: begin
				cmd.op  = ffha_pkg::DP_WALK_READ;
				state_d = S_WALK_EVAL;
			end
			S_WALK_EVAL: begin
				cmd.op = ffha_pkg::DP_WALK_EVAL;
				if (stat.free_cmd && stat.match) begin
					state_d = S_MERGE_READ0;
				end else if (!stat.free_cmd && stat.fit) begin
					state_d = stat.split ? S_SPLIT_WRITE : S_FINISH;
				end else begin
					state_d = stat.chain_end ? S_FINISH : S_WALK_READ;
				end
			end
			S_SPLIT_WRITE: begin
				cmd.op  = ffha_pkg::DP_SPLIT_WRITE;
				state_d = S_FINISH;
			end
			S_MERGE_READ0: begin
				cmd.op  = ffha_pkg::DP_MERGE_READ0;
				state_d = S_MERGE_LOAD0;
			end
			S_MERGE_LOAD0: begin
				cmd.op  = ffha_pkg::DP_MERGE_LOAD0;
				state_d = S_MERGE_READ;
			end
			S_MERGE_READ: begin
				cmd.op  = ffha_pkg::DP_MERGE_READ;
				state_d = stat.merge_end ? S_FINISH : S_MERGE_EVAL;
			end
			S_MERGE_EVAL: begin
				cmd.op  = ffha_pkg::DP_MERGE_EVAL;
				state_d = S_MERGE_READ;
			end
			S_FINISH: begin
				cmd.op = ffha_pkg::DP_FINISH;
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	`FFHA_ASSERT(a_accept_leaves_idle, clk, arst_n, accept |=> (state_q != S_IDLE))
	`FFHA_ASSERT(a_rsp_from_finish, clk, arst_n, $rose(rsp_valid) |-> $past(state_q == S_FINISH))
	`FFHA_ASSERT(a_finish_holds, clk, arst_n, (state_q == S_FINISH && rsp_valid_q && rsp_stall) |=> (state_q == S_FINISH))
	`FFHA_ASSERT_RST(a_no_rsp_in_reset, clk, !arst_n |-> !rsp_valid)

endmodule

`default_nettype wire
